>>> rtl/jpeg_marker_segment_parser_assert.svh
// ----------------------------------------------------------------------------
// JPEG marker/segment parser assertion macros
// Concurrent checks on clk, ignored while rst is high; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef JPEG_MARKER_SEGMENT_PARSER_ASSERT_SVH
`define JPEG_MARKER_SEGMENT_PARSER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define JMSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jmsp check failed");
// next-cycle implication
`define JMSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jmsp check failed");
`else
`define JMSP_ASSERT_NOW(label, ante, cons)
`define JMSP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/jmsp_pkg.sv
// ----------------------------------------------------------------------------
// jmsp_pkg
// Types, codes and helpers shared by the JPEG marker/segment parser.
// ----------------------------------------------------------------------------
package jmsp_pkg;

  localparam logic [7:0] PREFIX_BYTE = 8'hFF;
  localparam logic [7:0] STUFF_BYTE  = 8'h00;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_DATA    = 3'd1,
    KIND_MARKER  = 3'd2,
    KIND_LENGTH  = 3'd3,
    KIND_PAYLOAD = 3'd4,
    KIND_LENERR  = 3'd5
  } kind_t;

  typedef enum logic [4:0] {
    PH_SCAN    = 5'b00001,
    PH_AFTERFF = 5'b00010,
    PH_LENHI   = 5'b00100,
    PH_LENLO   = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  // Markers followed by a length field: SOFn/DHT/DAC (not JPG), SOS..APPF, COM.
  function automatic logic opens_segment(input logic [7:0] code);
    logic res;
    if (code[7:4] == 4'hC) begin
      res = (code != 8'hC8);
    end else if (code >= 8'hDA && code <= 8'hEF) begin
      res = 1'b1;
    end else begin
      res = (code == 8'hFE);
    end
    return res;
  endfunction

endpackage

>>> rtl/jmsp_byte_if.sv
// ----------------------------------------------------------------------------
// jmsp_byte_if
// Valid/ready channel carrying one raw stream byte per transaction.
// ----------------------------------------------------------------------------
interface jmsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

>>> rtl/jmsp_result_if.sv
// ----------------------------------------------------------------------------
// jmsp_result_if
// Valid/ready channel carrying one classified byte per transaction.
// ----------------------------------------------------------------------------
interface jmsp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] value;
  logic [7:0]  segment_marker;
  logic [15:0] payload_offset;
  logic        payload_last;

  modport source (output valid, output kind, output value, output segment_marker,
                  output payload_offset, output payload_last, input ready);
  modport sink   (input valid, input kind, input value, input segment_marker,
                  input payload_offset, input payload_last, output ready);
endinterface

>>> rtl/jpeg_marker_segment_parser.sv
// ----------------------------------------------------------------------------
// jpeg_marker_segment_parser
// Classifies a JPEG byte stream: entropy data, stuffed bytes, fill, markers,
// segment lengths, length errors and tagged segment payload bytes.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | per byte
//  stream  | in  | stream_byte[7:0]                               | 1 in
//  result  | out | kind[2:0] value[15:0] segment_marker[7:0]      | 1 out
//          |     | payload_offset[15:0] payload_last              |
//
// One byte per clock sustained while result.ready is high; each result is registered.
// The parse state and the result register update in the same cycle a byte
// transaction completes.
// A stalled result holds the register; stream.ready falls only while a result
// is waiting and result.ready is low, so the input side never idles otherwise.
// rst (synchronous) returns to scanning outside segments and drops result.valid.
// ----------------------------------------------------------------------------
`include "jpeg_marker_segment_parser_assert.svh"

module jpeg_marker_segment_parser
  import jmsp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  jmsp_byte_if.sink            stream,
  jmsp_result_if.source        result
);

  // parse state
  phase_t      phase,          phase_next;
  logic [7:0]  length_high,    length_high_next;
  logic [15:0] bytes_left,     bytes_left_next;
  logic [15:0] offset_count,   offset_count_next;
  logic [7:0]  current_marker, current_marker_next;

  // result register
  logic        res_valid;
  kind_t       res_kind,   kind_next;
  logic [15:0] res_value,  value_next;
  logic [7:0]  res_seg,    seg_next;
  logic [15:0] res_offs,   offs_next;
  logic        res_last,   last_next;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] seg_len;
  logic [15:0] left_dec;

  // Result register frees when empty or being drained this cycle.
  assign stream.ready = !res_valid || result.ready;
  assign accept       = stream.valid && stream.ready;
  assign b            = stream.stream_byte;

  assign result.valid          = res_valid;
  assign result.kind           = res_kind;
  assign result.value          = res_value;
  assign result.segment_marker = res_seg;
  assign result.payload_offset = res_offs;
  assign result.payload_last   = res_last;

  assign seg_len  = {length_high, b};
  assign left_dec = (bytes_left != 16'd0) ? (bytes_left - 16'd1) : 16'd0;

  always_comb begin
    phase_next          = phase;
    length_high_next    = length_high;
    bytes_left_next     = bytes_left;
    offset_count_next   = offset_count;
    current_marker_next = current_marker;
    kind_next           = KIND_NONE;
    value_next          = 16'd0;
    seg_next            = 8'd0;
    offs_next           = 16'd0;
    last_next           = 1'b0;
    unique case (phase)
      PH_AFTERFF: begin
        if (b == STUFF_BYTE) begin
          kind_next  = KIND_DATA;
          value_next = {8'd0, PREFIX_BYTE};
          phase_next = PH_SCAN;
        end else if (b == PREFIX_BYTE) begin
          kind_next  = KIND_NONE;        // fill, keep waiting for the code
        end else begin
          kind_next  = KIND_MARKER;
          value_next = {8'd0, b};
          if (opens_segment(b)) begin
            current_marker_next = b;
            seg_next            = b;
            phase_next          = PH_LENHI;
          end else begin
            phase_next = PH_SCAN;
          end
        end
      end
      PH_LENHI: begin
        length_high_next = b;
        seg_next         = current_marker;
        phase_next       = PH_LENLO;
      end
      PH_LENLO: begin
        seg_next   = current_marker;
        value_next = seg_len;
        if (seg_len < 16'd2) begin
          kind_next  = KIND_LENERR;        // segment abandoned
          phase_next = PH_SCAN;
        end else begin
          kind_next         = KIND_LENGTH;
          bytes_left_next   = seg_len - 16'd2;
          offset_count_next = 16'd0;
          phase_next        = (seg_len == 16'd2) ? PH_SCAN : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        kind_next         = KIND_PAYLOAD;
        value_next        = {8'd0, b};
        seg_next          = current_marker;
        offs_next         = offset_count;
        last_next         = (bytes_left <= 16'd1);
        offset_count_next = offset_count + 16'd1;
        bytes_left_next   = left_dec;
        if (left_dec == 16'd0) begin
          phase_next = PH_SCAN;
        end
      end
      default: begin                     // scanning outside segments
        if (b == PREFIX_BYTE) begin
          kind_next  = KIND_NONE;
          phase_next = PH_AFTERFF;
        end else begin
          kind_next  = KIND_DATA;
          value_next = {8'd0, b};
          phase_next = PH_SCAN;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SCAN;
      length_high    <= 8'd0;
      bytes_left     <= 16'd0;
      offset_count   <= 16'd0;
      current_marker <= 8'd0;
      res_valid      <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        length_high    <= length_high_next;
        bytes_left     <= bytes_left_next;
        offset_count   <= offset_count_next;
        current_marker <= current_marker_next;
        res_valid      <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res_kind  <= kind_next;
      res_value <= value_next;
      res_seg   <= seg_next;
      res_offs  <= offs_next;
      res_last  <= last_next;
    end
  end

  // payload phase always has bytes still to come
  `JMSP_ASSERT_NOW(a_payload_left, phase == PH_PAYLOAD, bytes_left != 16'd0)
  // FF 00 turns into a stuffed data byte
  `JMSP_ASSERT_NEXT(a_stuffed, accept && phase == PH_AFTERFF && b == STUFF_BYTE,
                    res_kind == KIND_DATA && res_value == 16'h00FF)
  // last payload byte closes the segment
  `JMSP_ASSERT_NEXT(a_seg_close, accept && phase == PH_PAYLOAD && bytes_left == 16'd1,
                    phase == PH_SCAN && res_last)
  // a non-final payload result leaves the parser inside the segment
  `JMSP_ASSERT_NOW(a_inside_seg, res_valid && res_kind == KIND_PAYLOAD && !res_last,
                   phase == PH_PAYLOAD)

endmodule
